FILE: src/dual_fir_bass_treble_tone_control_assert.svh
// ----------------------------------------------------------------------------
// Tone control assertion macros
// Concurrent checks on clk, with and without the reset qualifier.
// ----------------------------------------------------------------------------
`ifndef DUAL_FIR_BASS_TREBLE_TONE_CONTROL_ASSERT_SVH
`define DUAL_FIR_BASS_TREBLE_TONE_CONTROL_ASSERT_SVH

`ifndef NO_ASSERTIONS
// checked only outside reset
`define DFTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge
`define DFTC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DFTC_ASSERT(lbl, prop, msg)
`define DFTC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: src/dftc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dftc_pkg
// Shared constants, coefficient tables and control types of the tone control.
// ----------------------------------------------------------------------------
package dftc_pkg;

  localparam int DFTC_TAP_COUNT     = 17;
  localparam int DFTC_HISTORY_DEPTH = 64;
  localparam int DFTC_COEF_COUNT    = 17;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int FRAC_W   = 15;
  localparam int TERM_W   = PROD_W - FRAC_W;
  localparam int ACC_W    = 22;
  localparam int TAP_W    = 5;

  localparam logic [1:0] BTN_NONE   = 2'b00;
  localparam logic [1:0] BTN_BASS   = 2'b01;
  localparam logic [1:0] BTN_TREBLE = 2'b10;

  typedef struct packed {
    logic clr;     // clear accumulators and pending product
    logic mul_en;  // run the multiplier this cycle
    logic sel_hp;  // high-pass coefficient on the held sample
  } mac_ctl_t;

  function automatic logic signed [COEF_W-1:0] lp_coef(input logic [TAP_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      5'd0:    c = 16'sd652;
      5'd1:    c = 16'sd658;
      5'd2:    c = 16'sd664;
      5'd3:    c = 16'sd671;
      5'd4:    c = 16'sd675;
      5'd5:    c = 16'sd678;
      5'd6:    c = 16'sd681;
      5'd7:    c = 16'sd682;
      5'd8:    c = 16'sd682;
      5'd9:    c = 16'sd682;
      5'd10:   c = 16'sd682;
      5'd11:   c = 16'sd678;
      5'd12:   c = 16'sd675;
      5'd13:   c = 16'sd671;
      5'd14:   c = 16'sd664;
      5'd15:   c = 16'sd658;
      5'd16:   c = 16'sd652;
      default: c = 16'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [COEF_W-1:0] hp_coef(input logic [TAP_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    case (idx)
      5'd0:    c = -16'sd1130;
      5'd1:    c = -16'sd1436;
      5'd2:    c = -16'sd1740;
      5'd3:    c = -16'sd2013;
      5'd4:    c = -16'sd2257;
      5'd5:    c = -16'sd2458;
      5'd6:    c = -16'sd2608;
      5'd7:    c = -16'sd2698;
      5'd8:    c = 16'sd30036;
      5'd9:    c = -16'sd2698;
      5'd10:   c = -16'sd2608;
      5'd11:   c = -16'sd2458;
      5'd12:   c = -16'sd2257;
      5'd13:   c = -16'sd2013;
      5'd14:   c = -16'sd1740;
      5'd15:   c = -16'sd1436;
      5'd16:   c = -16'sd1130;
      default: c = 16'sd0;
    endcase
    return c;
  endfunction

endpackage

FILE: src/dftc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dftc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dftc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/dftc_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dftc_mac
// Shared multiplier and accumulator for the low-pass and high-pass sums.
// ----------------------------------------------------------------------------
module dftc_mac
  import dftc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctl_t                   ctl,
  input  logic [TAP_W-1:0]           tap,
  input  logic signed [SAMPLE_W-1:0] sample,
  output logic signed [ACC_W-1:0]    acc_lp,
  output logic signed [ACC_W-1:0]    acc_hp
);

  logic signed [SAMPLE_W-1:0] samp_r;
  logic signed [TERM_W-1:0]   prod_r;
  logic                       prod_vld_r, prod_vld_nxt;
  logic                       prod_hp_r;
  logic signed [ACC_W-1:0]    acc_lp_r, acc_lp_nxt;
  logic signed [ACC_W-1:0]    acc_hp_r, acc_hp_nxt;

  logic signed [COEF_W-1:0]   coef;
  logic signed [SAMPLE_W-1:0] opnd;
  logic signed [PROD_W-1:0]   mult;
  logic signed [ACC_W-1:0]    term;
  logic signed [ACC_W-1:0]    sum;

  always_comb begin
    coef = ctl.sel_hp ? hp_coef(tap) : lp_coef(tap);
    opnd = ctl.sel_hp ? samp_r : sample;
    mult = coef * opnd;
  end

  // add the previous cycle's product into the sum it belongs to
  always_comb begin
    term       = {{(ACC_W-TERM_W){prod_r[TERM_W-1]}}, prod_r};
    sum        = (prod_hp_r ? acc_hp_r : acc_lp_r) + term;
    acc_lp_nxt = acc_lp_r;
    acc_hp_nxt = acc_hp_r;
    if (ctl.clr) begin
      acc_lp_nxt = '0;
      acc_hp_nxt = '0;
    end else if (prod_vld_r) begin
      if (prod_hp_r) begin
        acc_hp_nxt = sum;
      end else begin
        acc_lp_nxt = sum;
      end
    end
    prod_vld_nxt = ctl.mul_en && !ctl.clr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      acc_lp_r   <= '0;
      acc_hp_r   <= '0;
    end else begin
      prod_vld_r <= prod_vld_nxt;
      acc_lp_r   <= acc_lp_nxt;
      acc_hp_r   <= acc_hp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      prod_r    <= mult[PROD_W-1:FRAC_W];
      prod_hp_r <= ctl.sel_hp;
      if (!ctl.sel_hp) begin
        samp_r <= sample;
      end
    end
  end

  assign acc_lp = acc_lp_r;
  assign acc_hp = acc_hp_r;

endmodule

FILE: src/dual_fir_bass_treble_tone_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_fir_bass_treble_tone_control
// Mono mix into a circular history, 17-tap low-pass and high-pass FIR on one
// shared MAC, button-toggled bass and treble enables.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------
//  in      | in_valid/in_stall  | in_left_sample, in_right_sample, in_buttons
//  out     | out_valid/out_stall| out_left_out, out_right_out
//
//  A word runs through a read state, then a low-pass and a high-pass MAC
//  pass per tap over min(TAP_COUNT, 17) taps, then a flush state and an output
//  state. A new word is not taken until the previous one has left S_OUT.
//  in_stall is high until the sequencer is idle. rst_n clears the enables, button
//  state, write slot and fill count; the fill count masks unwritten history slots.
//  A stalled result holds in the output register; the next word runs and waits.
// ----------------------------------------------------------------------------
module dual_fir_bass_treble_tone_control
  import dftc_pkg::*;
#(
  parameter int TAP_COUNT     = DFTC_TAP_COUNT,
  parameter int HISTORY_DEPTH = DFTC_HISTORY_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_left_sample,
  input  logic signed [SAMPLE_W-1:0] in_right_sample,
  input  logic [1:0]                 in_buttons,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] out_left_out,
  output logic signed [SAMPLE_W-1:0] out_right_out
);

  `include "dual_fir_bass_treble_tone_control_assert.svh"

  localparam int NUM_TAPS = (TAP_COUNT < DFTC_COEF_COUNT) ? TAP_COUNT : DFTC_COEF_COUNT;
  localparam int ADDR_W   = $clog2(HISTORY_DEPTH);
  localparam int FILL_W   = $clog2(HISTORY_DEPTH + 1);
  localparam logic [TAP_W-1:0]  LAST_TAP  = TAP_W'(NUM_TAPS - 1);
  localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(HISTORY_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_POS  = ADDR_W'(HISTORY_DEPTH - 1);
  localparam logic [ADDR_W:0]   DEPTH_X   = (ADDR_W + 1)'(HISTORY_DEPTH);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_LP    = 6'b000100,
    S_HP    = 6'b001000,
    S_FLUSH = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [TAP_W-1:0]    tap_r, tap_nxt;
  logic [ADDR_W-1:0]   wpos_r, wpos_nxt;
  logic [FILL_W-1:0]   fill_r, fill_nxt;
  logic                bass_on_r, bass_on_nxt;
  logic                treble_on_r, treble_on_nxt;
  logic [1:0]          prev_btn_r, prev_btn_nxt;
  logic                use_lp_r, use_hp_r;
  logic signed [SAMPLE_W-1:0] right_r;
  logic                out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_left_r, out_right_r;

  logic                       accept;
  logic                       out_free;
  logic                       out_load;
  logic signed [SAMPLE_W:0]   mix_sum;
  logic signed [SAMPLE_W-1:0] mono;
  logic [TAP_W-1:0]           rd_tap;
  logic [ADDR_W:0]            wpos_x, rd_tap_x, rd_addr_x;
  logic [ADDR_W-1:0]          rd_addr;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic signed [SAMPLE_W-1:0] tap_sample;
  mac_ctl_t                   mac_ctl;
  logic signed [ACC_W-1:0]    acc_lp, acc_hp;
  logic signed [SAMPLE_W-1:0] y_lp, y_hp, y_left;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_OUT) && out_free;

  // floor((l + r) / 2)
  assign mix_sum = {in_left_sample[SAMPLE_W-1], in_left_sample}
                 + {in_right_sample[SAMPLE_W-1], in_right_sample};
  assign mono    = mix_sum[SAMPLE_W:1];

  // read the tap j words back from the newest slot, wrapping around the ring
  always_comb begin
    rd_tap   = (state_r == S_HP) ? tap_r + TAP_W'(1) : '0;
    wpos_x   = {1'b0, wpos_r};
    rd_tap_x = (ADDR_W + 1)'(rd_tap);
    if (wpos_x >= rd_tap_x) begin
      rd_addr_x = wpos_x - rd_tap_x;
    end else begin
      rd_addr_x = wpos_x + DEPTH_X - rd_tap_x;
    end
    rd_addr = rd_addr_x[ADDR_W-1:0];
  end

  dftc_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (accept),
    .wr_addr (wpos_r),
    .wr_data (mono),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // slots not yet written since reset read as zero
  assign tap_sample = ((FILL_W + 1)'(tap_r) < (FILL_W + 1)'(fill_r)) ? rd_data : '0;

  always_comb begin
    mac_ctl.clr    = accept;
    mac_ctl.mul_en = (state_r == S_LP) || (state_r == S_HP);
    mac_ctl.sel_hp = (state_r == S_HP);
  end

  dftc_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .tap    (tap_r),
    .sample (tap_sample),
    .acc_lp (acc_lp),
    .acc_hp (acc_hp)
  );

  // sum times 4, wrapped to 16 bits
  assign y_lp   = {acc_lp[SAMPLE_W-3:0], 2'b00};
  assign y_hp   = {acc_hp[SAMPLE_W-3:0], 2'b00};
  assign y_left = (use_lp_r ? y_lp : '0) + (use_hp_r ? y_hp : '0);

  always_comb begin
    state_nxt     = state_r;
    tap_nxt       = tap_r;
    wpos_nxt      = wpos_r;
    fill_nxt      = fill_r;
    bass_on_nxt   = bass_on_r;
    treble_on_nxt = treble_on_r;
    prev_btn_nxt  = prev_btn_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          tap_nxt   = '0;
          state_nxt = S_RD;
          if (fill_r != FILL_FULL) begin
            fill_nxt = fill_r + FILL_W'(1);
          end
          // toggles count from the next word on
          if (in_buttons == BTN_BASS && prev_btn_r == BTN_NONE) begin
            bass_on_nxt = !bass_on_r;
          end
          if (in_buttons == BTN_TREBLE && prev_btn_r == BTN_NONE) begin
            treble_on_nxt = !treble_on_r;
          end
          prev_btn_nxt = in_buttons;
        end
      end
      S_RD: begin
        state_nxt = S_LP;
      end
      S_LP: begin
        state_nxt = S_HP;
      end
      S_HP: begin
        if (tap_r == LAST_TAP) begin
          state_nxt = S_FLUSH;
        end else begin
          tap_nxt   = tap_r + TAP_W'(1);
          state_nxt = S_LP;
        end
      end
      S_FLUSH: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          wpos_nxt      = (wpos_r == LAST_POS) ? '0 : wpos_r + ADDR_W'(1);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      tap_r       <= '0;
      wpos_r      <= '0;
      fill_r      <= '0;
      bass_on_r   <= 1'b0;
      treble_on_r <= 1'b0;
      prev_btn_r  <= BTN_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tap_r       <= tap_nxt;
      wpos_r      <= wpos_nxt;
      fill_r      <= fill_nxt;
      bass_on_r   <= bass_on_nxt;
      treble_on_r <= treble_on_nxt;
      prev_btn_r  <= prev_btn_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // enables in force for this word, taken before its own toggle
  always_ff @(posedge clk) begin
    if (accept) begin
      use_lp_r <= bass_on_r;
      use_hp_r <= treble_on_r;
      right_r  <= in_right_sample;
    end
    if (out_load) begin
      out_left_r  <= y_left;
      out_right_r <= right_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  `DFTC_ASSERT(a_accept_starts_read, accept |=> (state_r == S_RD && tap_r == '0), "accepted word did not start at tap zero")
  `DFTC_ASSERT(a_result_from_out_state, $rose(out_valid_r) |-> $past(state_r == S_OUT), "result raised outside output state")
  `DFTC_ASSERT(a_tap_in_range, (state_r == S_LP || state_r == S_HP) |-> tap_r <= LAST_TAP, "tap index beyond last tap")
  `DFTC_ASSERT(a_fill_bounded, fill_r <= FILL_FULL, "fill count beyond history depth")

endmodule
